// ===== hw/rtl/utf16_to_utf8_transcoder_defines.svh =====
// Assertion helpers shared by the transcoder RTL.
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define U16U8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define U16U8_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/u16u8_pkg.sv =====
package u16u8_pkg;

  localparam int unsigned ResultDepth = 6;
  localparam int unsigned CountW      = $clog2(ResultDepth + 1);
  localparam int unsigned PtrW        = $clog2(ResultDepth);

  localparam logic [1:0]  BomLen      = 2'd2;
  localparam logic [5:0]  SurHighTag  = 6'b110110;
  localparam logic [5:0]  SurLowTag   = 6'b110111;
  localparam logic [15:0] ReplUnit    = 16'hFFFD;
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [15:0] OneByteLim  = 16'h0080;
  localparam logic [15:0] TwoByteLim  = 16'h0800;

  localparam logic [7:0]  ContTag     = 8'h80;
  localparam logic [7:0]  Lead2Tag    = 8'hC0;
  localparam logic [7:0]  Lead3Tag    = 8'hE0;
  localparam logic [7:0]  Lead4Tag    = 8'hF0;
  localparam logic [7:0]  Repl0       = 8'hEF;
  localparam logic [7:0]  Repl1       = 8'hBF;
  localparam logic [7:0]  Repl2       = 8'hBD;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } utf8_seq_t;

  // Encode a non-surrogate BMP value as 1 to 3 bytes.
  function automatic utf8_seq_t encode_bmp(logic [15:0] v);
    utf8_seq_t s;
    s = '0;
    if (v < OneByteLim) begin
      s.cnt      = 3'd1;
      s.bytes[0] = v[7:0];
    end else if (v < TwoByteLim) begin
      s.cnt      = 3'd2;
      s.bytes[0] = Lead2Tag | {3'b000, v[10:6]};
      s.bytes[1] = ContTag | {2'b00, v[5:0]};
    end else begin
      s.cnt      = 3'd3;
      s.bytes[0] = Lead3Tag | {4'b0000, v[15:12]};
      s.bytes[1] = ContTag | {2'b00, v[11:6]};
      s.bytes[2] = ContTag | {2'b00, v[5:0]};
    end
    return s;
  endfunction

  // Combine a surrogate pair into a 4-byte sequence.
  function automatic utf8_seq_t encode_pair(logic [9:0] hi, logic [9:0] lo);
    utf8_seq_t   s;
    logic [20:0] cp;
    cp         = SuppBase + {1'b0, hi, lo};
    s.cnt      = 3'd4;
    s.bytes[0] = Lead4Tag | {5'b00000, cp[20:18]};
    s.bytes[1] = ContTag | {2'b00, cp[17:12]};
    s.bytes[2] = ContTag | {2'b00, cp[11:6]};
    s.bytes[3] = ContTag | {2'b00, cp[5:0]};
    return s;
  endfunction

endpackage

// ===== hw/rtl/utf16_to_utf8_transcoder.sv =====
// UTF-16 to UTF-8 transcoder.
// Input stream: one raw UTF-16 byte per transaction on s_axis (tdata = byte,
// tlast = final byte of the stream). The first two bytes (BOM) are dropped,
// then bytes pair into code units in the order set by byte_order_big
// (cfg_wr_en/cfg_wr_data, write only while idle).
// Output stream: one UTF-8 byte per transaction on m_axis; tlast marks the
// last byte caused by one input byte, tuser is set on bytes caused by the
// stream's final input byte. Lone or unpaired surrogates become U+FFFD.
// An accepted byte waits in the input register until the result buffer is
// free, and is then decoded into that buffer, from which m_axis reads it.
// An input byte yields 0 to 6 output bytes, sent on the one-byte output port
// one per m_axis transfer. While results drain, the input register can take
// one further byte; s_axis_tready then stays low until the buffer's last
// byte is taken, and the held byte is decoded as that last byte goes out.
// Reset clears the BOM counter, unit and surrogate state, the register, the
// input valid flag and the result count. A stalled m_axis_tready holds the
// current byte; the input register still takes one more byte, then
// s_axis_tready drops.
module utf16_to_utf8_transcoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,   // byte_order_big
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] in_byte
  input  logic                 s_axis_tlast,  // in_last
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [7:0] out_byte
  output logic                 m_axis_tlast,  // run_last
  output logic                 m_axis_tuser   // [0] stream_end
);
  import u16u8_pkg::*;
  `include "utf16_to_utf8_transcoder_defines.svh"

  logic                  byte_order_big;

  logic                  i_valid;
  byte_t                 i_byte;
  logic                  i_last;

  logic [1:0]            bom_cnt;
  logic                  unit_half;
  byte_t                 held_byte;
  logic                  pend;
  logic [9:0]            hi_bits;

  byte_t                 obuf [ResultDepth];
  logic [CountW-1:0]     buf_cnt;
  logic [PtrW-1:0]       rd_ptr;
  logic                  buf_end;

  logic                  out_done;
  logic                  buf_free;
  logic                  proc_go;
  logic [15:0]           unit;
  logic                  is_hi;
  logic                  is_lo;
  logic                  have_unit;
  logic                  pre;
  logic                  pair;
  logic                  pend_after;
  logic                  post;
  utf8_seq_t             main_seq;
  utf8_seq_t             tail_seq;
  utf8_seq_t             repl_seq;
  byte_t                 buf_next [ResultDepth];
  logic [CountW-1:0]     cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order_big <= 1'b0;
    end else if (cfg_wr_en) begin
      byte_order_big <= cfg_wr_data;
    end
  end

  // Output side
  assign m_axis_tvalid = (buf_cnt != '0);
  assign m_axis_tdata  = obuf[rd_ptr];
  assign m_axis_tlast  = (CountW'(rd_ptr) == buf_cnt - CountW'(1));
  assign m_axis_tuser  = buf_end;
  assign out_done      = m_axis_tvalid && m_axis_tready && m_axis_tlast;
  assign buf_free      = (buf_cnt == '0) || out_done;
  assign proc_go       = i_valid && buf_free;
  assign s_axis_tready = !i_valid || proc_go;

  // Decode
  assign unit       = byte_order_big ? {held_byte, i_byte} : {i_byte, held_byte};
  assign is_hi      = (unit[15:10] == SurHighTag);
  assign is_lo      = (unit[15:10] == SurLowTag);
  assign have_unit  = (bom_cnt == BomLen) && unit_half;
  assign pre        = have_unit && pend && !is_lo;
  assign pair       = have_unit && pend && is_lo;
  assign pend_after = have_unit ? is_hi : pend;
  assign post       = i_last && pend_after;

  always_comb begin
    repl_seq = '0;
    repl_seq.cnt      = 3'd3;
    repl_seq.bytes[0] = Repl0;
    repl_seq.bytes[1] = Repl1;
    repl_seq.bytes[2] = Repl2;

    if (pair) begin
      main_seq = encode_pair(hi_bits, unit[9:0]);
    end else if (have_unit && !is_hi) begin
      main_seq = encode_bmp(is_lo ? ReplUnit : unit);
    end else begin
      main_seq = '0;
    end

    tail_seq = post ? repl_seq : main_seq;

    // A leading replacement never shares the buffer with a 4-byte sequence.
    if (pre) begin
      buf_next[0] = Repl0;
      buf_next[1] = Repl1;
      buf_next[2] = Repl2;
      buf_next[3] = tail_seq.bytes[0];
      buf_next[4] = tail_seq.bytes[1];
      buf_next[5] = tail_seq.bytes[2];
      cnt_next    = CountW'(3) + CountW'(tail_seq.cnt);
    end else begin
      buf_next[0] = tail_seq.bytes[0];
      buf_next[1] = tail_seq.bytes[1];
      buf_next[2] = tail_seq.bytes[2];
      buf_next[3] = tail_seq.bytes[3];
      buf_next[4] = tail_seq.bytes[3];
      buf_next[5] = tail_seq.bytes[3];
      cnt_next    = CountW'(tail_seq.cnt);
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (s_axis_tready) begin
      i_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      i_byte <= s_axis_tdata;
      i_last <= s_axis_tlast;
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      bom_cnt   <= '0;
      unit_half <= 1'b0;
      pend      <= 1'b0;
    end else if (proc_go) begin
      if (i_last) begin
        bom_cnt   <= '0;
        unit_half <= 1'b0;
        pend      <= 1'b0;
      end else if (bom_cnt != BomLen) begin
        bom_cnt <= bom_cnt + 2'd1;
      end else begin
        unit_half <= !unit_half;
        pend      <= pend_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && (bom_cnt == BomLen)) begin
      if (!unit_half) begin
        held_byte <= i_byte;
      end else if (is_hi) begin
        hi_bits <= unit[9:0];
      end
    end
  end

  // Result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
      rd_ptr  <= '0;
    end else if (proc_go) begin
      buf_cnt <= cnt_next;
      rd_ptr  <= '0;
    end else if (out_done) begin
      buf_cnt <= '0;
      rd_ptr  <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      obuf    <= buf_next;
      buf_end <= i_last;
    end
  end

  `U16U8_ASSERT_NOW(a_cnt_range, 1'b1, buf_cnt <= CountW'(ResultDepth), "result count overflow")
  `U16U8_ASSERT_NOW(a_ptr_range, m_axis_tvalid, CountW'(rd_ptr) < buf_cnt, "read pointer past count")
  `U16U8_ASSERT_NOW(a_pend_bom, pend, bom_cnt == BomLen, "surrogate pending inside BOM")
  `U16U8_ASSERT_NXT(a_end_clear, proc_go && i_last,
                    bom_cnt == '0 && !pend && !unit_half, "state not cleared at stream end")

endmodule
